// ----- design/lse_pkg.sv -----
// Shared types and constants for the LSB stego extractor.
`timescale 1ns / 1ps
`default_nettype none

package lse_pkg;

  // Default width of the hidden length fields
  localparam int unsigned LENGTH_BITS_DEFAULT = 32;

  // Configuration register reset values
  localparam logic [7:0] HEADER_LENGTH_RESET = 8'd54;
  localparam logic [7:0] MAGIC_VALUE_RESET   = 8'd37;  // '%'

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_VALUE   = 1'b1;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_EXT   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

endpackage : lse_pkg

`default_nettype wire

// ----- design/lsb_stego_extract.sv -----
// LSB stego extractor: header skip, hidden frame parse and result register.
// A result appears on out_valid_o in the cycle after the byte that completes it is accepted.
// Throughput: one image byte per cycle while in_stall_o is low; the per-byte bit insert
// and counter update sit between the state registers and the result register.
// in_stall_o follows out_stall_i only while a result is held in the output register.
// Reset (rst_ni low, asynchronous) restores the register defaults and the header skip state.
`timescale 1ns / 1ps
`default_nettype none

module lsb_stego_extract #(
  parameter int unsigned LENGTH_BITS = lse_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // image byte channel
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [7:0]                      stego_byte_i,
  input  wire logic                            frame_start_i,
  // result channel
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [7:0]                      out_byte_o,
  output      lse_pkg::kind_e                  kind_o,
  output      logic                            last_o,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [lse_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                      cfg_data_i
);

  import lse_pkg::*;

  localparam int unsigned IW = $clog2(LENGTH_BITS);
  localparam logic [IW-1:0] BYTE_LAST = IW'(7);
  localparam logic [IW-1:0] LEN_LAST  = IW'(LENGTH_BITS - 1);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_MAGIC,
    PH_EXT_LEN,
    PH_EXT_DATA,
    PH_DATA_LEN,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } phase_e;

  phase_e                 phase_q, phase_d, cur_phase, eff_phase;
  logic [7:0]             hdr_cnt_q, hdr_cnt_d, cur_hdr_cnt;
  logic [IW-1:0]          bit_idx_q, bit_idx_d, cur_bit_idx;
  logic [LENGTH_BITS-1:0] acc_q, acc_d, cur_acc, acc_set;
  logic [LENGTH_BITS-1:0] left_q, left_d, cur_left, left_dec;
  logic [7:0]             hdr_len_q, magic_q;

  logic                   in_accept, skip_byte, byte_done, len_done;
  logic                   res_valid, res_last;
  logic [7:0]             res_byte;
  kind_e                  res_kind;

  logic                   out_valid_q, last_q;
  logic [7:0]             out_byte_q;
  kind_e                  kind_q;

  // Accept while the result slot is empty or being drained
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Clear the frame state at frame start
  always_comb begin
    cur_phase   = frame_start_i ? PH_HEADER : phase_q;
    cur_hdr_cnt = frame_start_i ? 8'd0 : hdr_cnt_q;
    cur_bit_idx = frame_start_i ? '0 : bit_idx_q;
    cur_acc     = frame_start_i ? '0 : acc_q;
    cur_left    = frame_start_i ? '0 : left_q;
  end

  // Insert the hidden bit and decode field completion
  assign skip_byte = (cur_phase == PH_HEADER) && (cur_hdr_cnt < hdr_len_q);
  assign eff_phase = (cur_phase == PH_HEADER) ? PH_MAGIC : cur_phase;
  assign acc_set   = cur_acc | (LENGTH_BITS'(stego_byte_i[0]) << cur_bit_idx);
  assign byte_done = (cur_bit_idx == BYTE_LAST);
  assign len_done  = (cur_bit_idx == LEN_LAST);
  assign left_dec  = cur_left - LENGTH_BITS'(1);

  // Advance the frame parser for one byte
  always_comb begin
    phase_d   = cur_phase;
    hdr_cnt_d = cur_hdr_cnt;
    bit_idx_d = cur_bit_idx;
    acc_d     = cur_acc;
    left_d    = cur_left;
    res_valid = 1'b0;
    res_byte  = acc_set[7:0];
    res_kind  = KIND_EXT;
    res_last  = 1'b0;
    if (skip_byte) begin
      hdr_cnt_d = cur_hdr_cnt + 8'd1;
    end else begin
      unique case (eff_phase)
        PH_MAGIC: begin
          if (byte_done) begin
            bit_idx_d = '0;
            acc_d     = '0;
            if (acc_set[7:0] == magic_q) begin
              phase_d = PH_EXT_LEN;
            end else begin
              phase_d   = PH_ERROR;
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
            end
          end else begin
            phase_d   = PH_MAGIC;
            bit_idx_d = cur_bit_idx + IW'(1);
            acc_d     = acc_set;
          end
        end
        PH_EXT_LEN, PH_DATA_LEN: begin
          if (len_done) begin
            bit_idx_d = '0;
            acc_d     = '0;
            left_d    = acc_set;
            if (eff_phase == PH_EXT_LEN) begin
              phase_d = (acc_set != '0) ? PH_EXT_DATA : PH_DATA_LEN;
            end else begin
              phase_d = (acc_set != '0) ? PH_DATA : PH_DONE;
            end
          end else begin
            bit_idx_d = cur_bit_idx + IW'(1);
            acc_d     = acc_set;
          end
        end
        PH_EXT_DATA, PH_DATA: begin
          if (byte_done) begin
            bit_idx_d = '0;
            acc_d     = '0;
            left_d    = left_dec;
            res_valid = 1'b1;
            res_kind  = (eff_phase == PH_DATA) ? KIND_DATA : KIND_EXT;
            res_last  = (left_dec == '0);
            if (left_dec == '0) begin
              phase_d = (eff_phase == PH_DATA) ? PH_DONE : PH_DATA_LEN;
            end
          end else begin
            bit_idx_d = cur_bit_idx + IW'(1);
            acc_d     = acc_set;
          end
        end
        default: begin
          // done or error: drop the byte
        end
      endcase
    end
  end

  // Hold parser state, configuration and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= 8'd0;
      bit_idx_q   <= '0;
      acc_q       <= '0;
      left_q      <= '0;
      hdr_len_q   <= HEADER_LENGTH_RESET;
      magic_q     <= MAGIC_VALUE_RESET;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      kind_q      <= KIND_EXT;
      last_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_HEADER_LENGTH: hdr_len_q <= cfg_data_i;
          CFG_MAGIC_VALUE:   magic_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_accept) begin
        phase_q   <= phase_d;
        hdr_cnt_q <= hdr_cnt_d;
        bit_idx_q <= bit_idx_d;
        acc_q     <= acc_d;
        left_q    <= left_d;
      end
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= in_accept && res_valid;
      end
      if (in_accept && res_valid) begin
        out_byte_q <= res_byte;
        kind_q     <= res_kind;
        last_q     <= res_last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;

  // Checks on parser and result slot consistency
  a_err_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_ERROR) |-> !last_o)
    else $error("error result flagged as last");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_byte_o)))
    else $error("held result lost or overwritten");

  a_byte_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MAGIC || phase_q == PH_EXT_DATA || phase_q == PH_DATA)
      |-> (bit_idx_q <= BYTE_LAST))
    else $error("bit index past byte field");

  a_run_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXT_DATA || phase_q == PH_DATA) |-> (left_q != '0))
    else $error("byte run entered with no bytes left");

endmodule : lsb_stego_extract

`default_nettype wire
